// ===== design/keyed_entry_set_with_crc_signature_assert.svh =====
// Assertion macros used by the checker file of the keyed entry set.
// No dependencies; expects a clock named clock and a reset named reset in scope.
`ifndef KEYED_ENTRY_SET_WITH_CRC_SIGNATURE_ASSERT_SVH
`define KEYED_ENTRY_SET_WITH_CRC_SIGNATURE_ASSERT_SVH

// same-cycle implication
`define KES_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed entry set check failed");

// next-cycle implication
`define KES_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed entry set check failed");

`endif

// ===== design/kes_pkg.sv =====
// Package for the keyed entry set: beat types, entry type, codes and CRC constants.
// No dependencies.
`timescale 1ns / 1ps

package kes_pkg;

   localparam int COUNT_W = 7;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_DUP     = 2'd2;
   localparam logic [1:0] STATUS_MISSING = 2'd3;

   localparam logic [1:0] LAST_BYTE = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] entry_key;
      logic [15:0] entry_size;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        set_signature;
      logic [15:0]        total_size;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] size;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_APPEND,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_CRC_START,
      S_CRC_RD,
      S_CRC_BYTE,
      S_DONE
   } state_type;

endpackage

// ===== design/keyed_entry_set_with_crc_signature.sv =====
// Top level of the keyed entry set with CRC signature: capacity register,
// result register, sequencer and entry memory. Depends on kes_pkg, kes_ctrl, kes_store.
//
//   channel | dir | handshake           | beat
//   req     | in  | req_valid/req_stall | req_type: operation, entry_key, entry_size
//   rsp     | out | rsp_valid/rsp_stall | rsp_type: status, signature, total, count
//   csr     | in  | csr_valid/csr_ready | capacity, 7 bits
//
// One request at a time; req_stall stays high until its result is loaded.
// A request scans the entries, closes a gap by moving the later entries down (remove) or
// appends (add), then walks every entry for the CRC signature and total size (one key byte
// per cycle through the shared CRC step, read from the entry memory's read port).
// Full, duplicate and not-found requests skip the walk. A result waits
// in the output register under rsp_stall while the next request is taken.
// Reset is synchronous: empty list, signature 0xFFFF, capacity 64; memory is not cleared.
`timescale 1ns / 1ps

module keyed_entry_set_with_crc_signature
   import kes_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

   logic [COUNT_W-1:0] capacity_ff, capacity_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               done;
   rsp_type            result;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   entry_type          mem_wdata;
   logic [AW-1:0]      mem_raddr;
   entry_type          mem_rdata;

   assign csr_ready = !reset;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   kes_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .capacity  (capacity_ff),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   kes_store #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      capacity_in  = capacity_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/kes_store.sv =====
// Entry memory: one write port, one registered read port.
// Depends on kes_pkg for the entry type.
`timescale 1ns / 1ps

module kes_store
   import kes_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type store_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kes_crc_unit.sv =====
// Shared CRC-16 byte step (poly 0x1021, MSB first), reused for every key byte.
// Depends on kes_pkg for the CRC constants.
`timescale 1ns / 1ps

module kes_crc_unit
   import kes_pkg::*;
(
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {data_in, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      crc_out = c;
   end

endmodule

// ===== design/kes_ctrl.sv =====
// Sequencer for the keyed entry set: key scan, gap close, append and CRC walk.
// Depends on kes_pkg, kes_crc_unit; drives the kes_store ports of the top level.
`timescale 1ns / 1ps

module kes_ctrl
   import kes_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int AW          = 6,
   parameter int CW          = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   input  logic [COUNT_W-1:0]  capacity,
   input  logic                out_free,
   output logic                done,
   output rsp_type             result,
   output logic                mem_we,
   output logic [AW-1:0]       mem_waddr,
   output entry_type           mem_wdata,
   output logic [AW-1:0]       mem_raddr,
   input  entry_type           mem_rdata
);

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [1:0]      byte_ff, byte_in;
   logic [15:0]     crc_ff, crc_in;
   logic [15:0]     sum_ff, sum_in;
   logic [15:0]     crcw_ff, crcw_in;
   logic [15:0]     sumw_ff, sumw_in;
   logic [1:0]      status_ff, status_in;

   logic [CW-1:0]   cap_ext;
   logic [CW-1:0]   limit;
   logic            at_limit;
   logic [CW-1:0]   idx_plus1;
   logic [CW-1:0]   idx_plus2;
   logic            next_is_end;
   logic            key_hit;
   logic            is_add;
   logic [7:0]      key_byte;
   logic [15:0]     crc_step;

   assign cap_ext     = CW'(capacity);
   assign limit       = (cap_ext < MAX_CNT) ? cap_ext : MAX_CNT;
   assign at_limit    = (count_ff >= limit);
   assign idx_plus1   = idx_ff + CW'(1);
   assign idx_plus2   = idx_ff + CW'(2);
   assign next_is_end = (idx_plus1 == count_ff);
   assign key_hit     = (mem_rdata.key == req_ff.entry_key);
   assign is_add      = (req_ff.operation == OP_ADD);
   assign key_byte    = mem_rdata.key[{byte_ff, 3'b000} +: 8];

   kes_crc_unit u_crc (
      .crc_in  (crcw_ff),
      .data_in (key_byte),
      .crc_out (crc_step)
   );

   assign req_stall = reset || (state_ff != S_IDLE);
   assign result    = '{status_ff, crc_ff, sum_ff, count_ff[COUNT_W-1:0]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (req_ff.operation)
               OP_ADD: begin
                  if (at_limit) begin
                     state_in = S_DONE;
                  end else if (count_ff == '0) begin
                     state_in = S_APPEND;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               OP_REMOVE: state_in = (count_ff == '0) ? S_DONE : S_SCAN_RD;
               OP_CLEAR:  state_in = S_CRC_START;
               default:   state_in = S_DONE;
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (key_hit) begin
               if (is_add) begin
                  state_in = S_DONE;
               end else begin
                  state_in = next_is_end ? S_CRC_START : S_SHIFT_RD;
               end
            end else if (next_is_end) begin
               state_in = is_add ? S_APPEND : S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_APPEND:   state_in = S_CRC_START;
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = (idx_plus2 < count_ff) ? S_SHIFT_RD : S_CRC_START;
         S_CRC_START: state_in = (count_ff == '0) ? S_DONE : S_CRC_RD;
         S_CRC_RD:    state_in = S_CRC_BYTE;
         S_CRC_BYTE: begin
            if ((byte_ff == LAST_BYTE) && next_is_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      byte_in   = byte_ff;
      crc_in    = crc_ff;
      sum_in    = sum_ff;
      crcw_in   = crcw_ff;
      sumw_in   = sumw_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = '{req_ff.entry_key, req_ff.entry_size};
      mem_raddr = idx_ff[AW-1:0];
      done      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_in = req_data;
         end
         S_CHECK: begin
            idx_in = '0;
            case (req_ff.operation)
               OP_ADD:    status_in = at_limit ? STATUS_FULL : STATUS_OK;
               OP_REMOVE: status_in = STATUS_MISSING;
               OP_CLEAR: begin
                  status_in = STATUS_OK;
                  count_in  = '0;
               end
               default:   status_in = STATUS_OK;
            endcase
         end
         S_SCAN_CMP: begin
            if (key_hit) begin
               if (is_add) begin
                  status_in = STATUS_DUP;
               end else begin
                  status_in = STATUS_OK;
                  if (next_is_end) begin
                     count_in = count_ff - CW'(1);
                  end
               end
            end else begin
               idx_in = idx_plus1;
            end
         end
         S_APPEND: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
         end
         S_SHIFT_RD: begin
            mem_raddr = idx_plus1[AW-1:0];
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = mem_rdata;
            idx_in    = idx_plus1;
            if (!(idx_plus2 < count_ff)) begin
               count_in = count_ff - CW'(1);
            end
         end
         S_CRC_START: begin
            crcw_in = CRC_INIT;
            sumw_in = '0;
            idx_in  = '0;
            if (count_ff == '0) begin
               crc_in = CRC_INIT;
               sum_in = '0;
            end
         end
         S_CRC_RD: begin
            byte_in = '0;
         end
         S_CRC_BYTE: begin
            crcw_in = crc_step;
            byte_in = byte_ff + 2'd1;
            if (byte_ff == '0) begin
               sumw_in = sumw_ff + mem_rdata.size;
            end
            if (byte_ff == LAST_BYTE) begin
               if (next_is_end) begin
                  crc_in = crc_step;
                  sum_in = sumw_ff;
               end else begin
                  idx_in    = idx_plus1;
                  mem_raddr = idx_plus1[AW-1:0];
               end
            end
         end
         S_DONE: begin
            done = out_free;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      byte_ff   <= byte_in;
      crcw_ff   <= crcw_in;
      sumw_ff   <= sumw_in;
      status_ff <= status_in;
   end

endmodule

// ===== design/kes_checker.sv =====
// Port-level checks for the keyed entry set, bound to the top level.
// Depends on kes_pkg and keyed_entry_set_with_crc_signature_assert.svh.
`timescale 1ns / 1ps
`include "keyed_entry_set_with_crc_signature_assert.svh"

module kes_port_checker
   import kes_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `KES_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `KES_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

   `KES_ASSERT_NOW(a_empty_sums, rsp_valid && (rsp_data.entry_count == '0),
      (rsp_data.set_signature == CRC_INIT) && (rsp_data.total_size == '0))

   `KES_ASSERT_NOW(a_dup_needs_entry, rsp_valid && (rsp_data.status == STATUS_DUP),
      rsp_data.entry_count != '0)

endmodule

bind keyed_entry_set_with_crc_signature kes_port_checker u_kes_checker (.*);
